FILE: src/vnu_pkg.sv
// Package: shared types and constants for the vector normalize unit.
package vnu_pkg;

   localparam int CompWidth = 32;
   localparam int RadWidth  = 2 * CompWidth;
   localparam int RemWidth  = CompWidth + 2;
   localparam int QuotWidth = 15;
   localparam int Lanes     = 3;
   localparam int SqrtCells = CompWidth;
   localparam int DivCells  = QuotWidth;
   localparam logic [15:0] UnitMax = 16'd32767;

   typedef struct packed {
      logic signed [CompWidth-1:0] vec_x;
      logic signed [CompWidth-1:0] vec_y;
      logic signed [CompWidth-1:0] vec_z;
   } vnu_req_type;

   typedef struct packed {
      logic [CompWidth-1:0] length;
      logic signed [15:0]   unit_x;
      logic signed [15:0]   unit_y;
      logic signed [15:0]   unit_z;
      logic                 is_zero;
   } vnu_rsp_type;

   typedef struct packed {
      logic                             valid;
      logic [RadWidth-1:0]              rad;
      logic [RemWidth-1:0]              rem;
      logic [CompWidth-1:0]             root;
      logic [Lanes-1:0][CompWidth-1:0]  mag;
      logic [Lanes-1:0]                 neg;
   } vnu_sqrt_type;

   typedef struct packed {
      logic                             valid;
      logic [CompWidth-1:0]             len;
      logic                             zero;
      logic [Lanes-1:0]                 neg;
      logic [Lanes-1:0]                 sat;
      logic [Lanes-1:0][CompWidth-1:0]  rem;
      logic [Lanes-1:0][QuotWidth-1:0]  quot;
   } vnu_div_type;

endpackage

FILE: src/vnu_sqrt_cell.sv
// One root digit cell of the square root chain.
module vnu_sqrt_cell
   import vnu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  vnu_sqrt_type up,
   output vnu_sqrt_type down
);

   vnu_sqrt_type        down_ff, down_in;
   logic [RemWidth+1:0] shifted;
   logic [RemWidth+1:0] trial;
   logic                ge;

   always_comb begin
      shifted = {up.rem, up.rad[RadWidth-1 -: 2]};
      trial   = {2'b00, up.root, 2'b01};
      ge      = shifted >= trial;
      down_in = up;
      down_in.rad  = {up.rad[RadWidth-3:0], 2'b00};
      down_in.rem  = ge ? RemWidth'(shifted - trial) : shifted[RemWidth-1:0];
      down_in.root = {up.root[CompWidth-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff.valid <= 1'b0;
      end else begin
         down_ff.valid <= up.valid;
      end
   end

   always_ff @(posedge clock) begin
      down_ff.rad  <= down_in.rad;
      down_ff.rem  <= down_in.rem;
      down_ff.root <= down_in.root;
      down_ff.mag  <= down_in.mag;
      down_ff.neg  <= down_in.neg;
   end

   assign down = down_ff;

endmodule

FILE: src/vnu_div_cell.sv
// One quotient bit cell of the three-lane divide chain.
module vnu_div_cell
   import vnu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  vnu_div_type up,
   output vnu_div_type down
);

   vnu_div_type        down_ff, down_in;
   logic [CompWidth:0] shifted [Lanes];
   logic [Lanes-1:0]   ge;

   always_comb begin
      down_in = up;
      for (int i = 0; i < Lanes; i++) begin
         shifted[i] = {up.rem[i], 1'b0};
         ge[i]      = shifted[i] >= {1'b0, up.len};
         down_in.rem[i]  = ge[i] ? CompWidth'(shifted[i] - {1'b0, up.len})
                                 : shifted[i][CompWidth-1:0];
         down_in.quot[i] = {up.quot[i][QuotWidth-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff.valid <= 1'b0;
      end else begin
         down_ff.valid <= up.valid;
      end
   end

   always_ff @(posedge clock) begin
      down_ff.len  <= down_in.len;
      down_ff.zero <= down_in.zero;
      down_ff.neg  <= down_in.neg;
      down_ff.sat  <= down_in.sat;
      down_ff.rem  <= down_in.rem;
      down_ff.quot <= down_in.quot;
   end

   assign down = down_ff;

endmodule

FILE: src/vector_normalize_unit.sv
// Top level: vector length and unit direction over root and divide cell chains.
// Throughput: one beat per cycle; busy is always low.
// The 32 root cells and 15 divide cells, with the s0, s1, root head and result registers, set the latency.
// Reset clears all valid bits; beats in flight are dropped.
// The receiver cannot stall; each result shows for one cycle.
module vector_normalize_unit
   import vnu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  vnu_req_type req,
   output logic        rsp_valid,
   output vnu_rsp_type rsp
);

   logic                            s0_valid_ff;
   logic [Lanes-1:0][CompWidth-1:0] s0_mag_ff;
   logic [Lanes-1:0]                s0_neg_ff;
   logic                            s1_valid_ff;
   logic [Lanes-1:0][CompWidth-1:0] s1_mag_ff;
   logic [Lanes-1:0]                s1_neg_ff;
   logic [Lanes-1:0][RadWidth-1:0]  s1_sq_ff;
   logic [CompWidth-1:0]            comp [Lanes];
   vnu_sqrt_type                    sq_chain [SqrtCells+1];
   vnu_sqrt_type                    sq_head_ff;
   vnu_div_type                     dv_chain [DivCells+1];
   vnu_sqrt_type                    sq_tail;
   vnu_div_type                     dv_tail;
   vnu_rsp_type                     rsp_ff, rsp_in;
   logic                            rsp_valid_ff;
   logic [15:0]                     unit [Lanes];

   assign busy    = 1'b0;
   assign comp[0] = req.vec_x;
   assign comp[1] = req.vec_y;
   assign comp[2] = req.vec_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         sq_head_ff.valid <= 1'b0;
      end else begin
         s0_valid_ff <= start && !busy;
         s1_valid_ff <= s0_valid_ff;
         sq_head_ff.valid <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < Lanes; i++) begin
         s0_neg_ff[i] <= comp[i][CompWidth-1];
         s0_mag_ff[i] <= comp[i][CompWidth-1] ? (~comp[i] + CompWidth'(1)) : comp[i];
         s1_sq_ff[i]  <= RadWidth'(s0_mag_ff[i]) * RadWidth'(s0_mag_ff[i]);
      end
      s1_mag_ff       <= s0_mag_ff;
      s1_neg_ff       <= s0_neg_ff;
      sq_head_ff.rad  <= s1_sq_ff[0] + s1_sq_ff[1] + s1_sq_ff[2];
      sq_head_ff.rem  <= '0;
      sq_head_ff.root <= '0;
      sq_head_ff.mag  <= s1_mag_ff;
      sq_head_ff.neg  <= s1_neg_ff;
   end

   assign sq_chain[0] = sq_head_ff;

   for (genvar g = 0; g < SqrtCells; g++) begin : g_sqrt
      vnu_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .up    (sq_chain[g]),
         .down  (sq_chain[g+1])
      );
   end

   assign sq_tail = sq_chain[SqrtCells];

   always_comb begin
      dv_chain[0].valid = sq_tail.valid;
      dv_chain[0].len   = sq_tail.root;
      dv_chain[0].zero  = sq_tail.root == '0;
      dv_chain[0].neg   = sq_tail.neg;
      for (int i = 0; i < Lanes; i++) begin
         dv_chain[0].sat[i]  = sq_tail.mag[i] >= sq_tail.root;
         dv_chain[0].rem[i]  = dv_chain[0].sat[i] ? '0 : sq_tail.mag[i];
         dv_chain[0].quot[i] = '0;
      end
   end

   for (genvar g = 0; g < DivCells; g++) begin : g_div
      vnu_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .up    (dv_chain[g]),
         .down  (dv_chain[g+1])
      );
   end

   assign dv_tail = dv_chain[DivCells];

   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         unit[i] = dv_tail.sat[i] ? UnitMax : {1'b0, dv_tail.quot[i]};
         if (dv_tail.zero) begin
            unit[i] = '0;
         end else if (dv_tail.neg[i]) begin
            unit[i] = ~unit[i] + 16'd1;
         end
      end
      rsp_in.length  = dv_tail.len;
      rsp_in.unit_x  = unit[0];
      rsp_in.unit_y  = unit[1];
      rsp_in.unit_z  = unit[2];
      rsp_in.is_zero = dv_tail.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTH
   a_zero_len : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.is_zero == (rsp.length == '0)))
      else $error("is_zero disagrees with length");

   a_zero_unit : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.is_zero) |->
         (rsp.unit_x == '0 && rsp.unit_y == '0 && rsp.unit_z == '0))
      else $error("zero vector with nonzero unit");

   a_no_min : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.unit_x != 16'sh8000 && rsp.unit_y != 16'sh8000
                     && rsp.unit_z != 16'sh8000))
      else $error("unit component out of saturated range");
`endif

endmodule

FILE: tb/vnu_checker.sv
// Checker: predicts vector length and unit direction and compares each result beat.
module vnu_checker
   import vnu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  vnu_req_type req,
   input  logic        rsp_valid,
   input  vnu_rsp_type rsp,
   output int          fail_count,
   output int          pending
);

   vnu_rsp_type norm_q[$];

   function automatic logic [31:0] floor_root(logic [63:0] n);
      logic [63:0] root;
      logic [63:0] bitv;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root[31:0];
   endfunction

   function automatic logic [15:0] unit_comp(logic signed [31:0] c, logic [31:0] len);
      logic [63:0] mag;
      logic [63:0] q;
      mag = c[31] ? {32'd0, -c} : {32'd0, c};
      if (len == 0) return 16'd0;
      q = (mag << 15) / len;
      if (q > 64'd32767) q = 64'd32767;
      if (c[31]) q = -q;
      return q[15:0];
   endfunction

   function automatic vnu_rsp_type normalize(vnu_req_type v);
      vnu_rsp_type r;
      logic [63:0] mx, my, mz;
      mx = v.vec_x[31] ? {32'd0, -v.vec_x} : {32'd0, v.vec_x};
      my = v.vec_y[31] ? {32'd0, -v.vec_y} : {32'd0, v.vec_y};
      mz = v.vec_z[31] ? {32'd0, -v.vec_z} : {32'd0, v.vec_z};
      r.length  = floor_root(mx * mx + my * my + mz * mz);
      r.unit_x  = unit_comp(v.vec_x, r.length);
      r.unit_y  = unit_comp(v.vec_y, r.length);
      r.unit_z  = unit_comp(v.vec_z, r.length);
      r.is_zero = (r.length == 0);
      return r;
   endfunction

   always_ff @(posedge clock) begin
      vnu_rsp_type e;
      if (reset) begin
         fail_count <= 0;
         pending    <= 0;
      end else begin
         if (start && !busy) norm_q.push_back(normalize(req));
         if (rsp_valid) begin
            if (norm_q.size() == 0) begin
               $error("result beat with none expected");
               fail_count <= fail_count + 1;
            end else begin
               e = norm_q.pop_front();
               if (rsp !== e) begin
                  fail_count <= fail_count + 1;
                  if (rsp.length !== e.length)
                     $error("length exp %h got %h", e.length, rsp.length);
                  if (rsp.unit_x !== e.unit_x)
                     $error("unit_x exp %h got %h", e.unit_x, rsp.unit_x);
                  if (rsp.unit_y !== e.unit_y)
                     $error("unit_y exp %h got %h", e.unit_y, rsp.unit_y);
                  if (rsp.unit_z !== e.unit_z)
                     $error("unit_z exp %h got %h", e.unit_z, rsp.unit_z);
                  if (rsp.is_zero !== e.is_zero)
                     $error("is_zero exp %b got %b", e.is_zero, rsp.is_zero);
               end
            end
         end
         pending <= norm_q.size();
      end
   end

endmodule

FILE: tb/tb.sv
// Testbench top: drives vector beats into the normalize unit and reports the verdict.
module tb;
   import vnu_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   vnu_req_type req = '0;
   logic        rsp_valid;
   vnu_rsp_type rsp;
   int          fail_count;
   int          pending;
   int          cycles = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   vector_normalize_unit dut (.*);

   vnu_checker chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 200000) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic [31:0] pick_comp(int mode);
      case (mode)
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'd0;
         3: return $urandom_range(0, 255) - 128;
         4: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
         default: return $urandom();
      endcase
   endfunction

   task automatic send(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      int gap;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req <= '{vec_x: x, vec_y: y, vec_z: z};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      logic [31:0] a;
      repeat (4) @(posedge clock);
      reset <= 0;
      send(0, 0, 0);
      send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send(32'h8000_0000, 0, 0);
      send(32'h7FFF_FFFF, 0, 0);
      send(0, 32'hFFFF_FFFF, 0);
      send(0, 0, 1);
      send(0, 0, 32'hFFFF_FFFF);
      send(32'h0001_0000, 0, 0);
      send(0, 32'hFFFF_0000, 0);
      send(32'h0003_0000, 32'h0004_0000, 0);
      send(32'hFFFF_FFFD, 32'h0000_0004, 32'hFFFF_FFF4);
      send(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
      send(1, 1, 1);
      repeat (936) begin
         a = pick_comp($urandom_range(0, 5));
         if ($urandom_range(0, 9) == 0)
            send(a, 0, 0);
         else
            send(pick_comp($urandom_range(0, 7)), pick_comp($urandom_range(0, 7)),
                 pick_comp($urandom_range(0, 7)));
      end
      start <= 0;
      while (pending > 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
